// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file dhse_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, quiet while reset is asserted.
`define DHSE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define DHSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  `DHSE_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication.
`define DHSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  `DHSE_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ===== rtl/dhse_pkg.sv =====
`default_nettype none
package dhse_pkg;

  // Parse phases of the datagram walker
  typedef enum logic [2:0] {
    PH_REC_HDR  = 3'd0,
    PH_SKIP     = 3'd1,
    PH_MSG_HDR  = 3'd2,
    PH_FRAGMENT = 3'd3
  } phase_t;

  // Result kinds on the output channel
  typedef enum logic [1:0] {
    KIND_SEQ = 2'd0,
    KIND_OK  = 2'd1,
    KIND_BAD = 2'd2
  } kind_t;

  // Record header layout (13 bytes, big-endian)
  localparam logic [3:0] REC_HDR_LEN  = 4'd13;
  localparam logic [3:0] REC_TYPE_POS = 4'd0;
  localparam logic [3:0] REC_EPOCH_HI = 4'd3;
  localparam logic [3:0] REC_EPOCH_LO = 4'd4;
  localparam logic [3:0] REC_LEN_HI   = 4'd11;
  localparam logic [3:0] REC_LEN_LO   = 4'd12;
  localparam logic [7:0] HANDSHAKE_TYPE = 8'd22;

  // Handshake message header layout (12 bytes, big-endian)
  localparam logic [3:0] MSG_HDR_LEN  = 4'd12;
  localparam logic [3:0] MSG_SEQ_HI   = 4'd4;
  localparam logic [3:0] MSG_SEQ_LO   = 4'd5;
  localparam logic [3:0] MSG_FRAG_B2  = 4'd9;
  localparam logic [3:0] MSG_FRAG_B1  = 4'd10;
  localparam logic [3:0] MSG_FRAG_B0  = 4'd11;

  // Default depth of the queue between parser and output stage
  localparam int DHSE_QDEPTH = 4;

  // Results caused by one input byte
  typedef struct packed {
    logic        seq_valid;
    logic [15:0] seq;
    logic        status_valid;
    logic        status_bad;
  } res_entry_t;

endpackage
`default_nettype wire

// ===== rtl/dhse_if.sv =====
`default_nettype none
// Byte stream channel
interface dhse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink (input valid, input data_byte, input end_of_packet, output ready);
endinterface

// Result channel
interface dhse_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] hs_seq;
  logic        last_result;

  modport source (output valid, output result_kind, output hs_seq,
                  output last_result, input ready);
  modport sink (input valid, input result_kind, input hs_seq,
                input last_result, output ready);
endinterface
`default_nettype wire

// ===== rtl/dtls_handshake_seq_extractor.sv =====
`default_nettype none
// DTLS 1.2 handshake sequence extractor. Takes one datagram byte per transfer
// on in_ch, with end_of_packet on the final byte, walks the 13-byte record
// headers and, inside epoch-0 handshake records, the 12-byte message headers,
// and returns on out_ch each handshake message sequence number whose fragment
// completes, followed by one ok or malformed status per packet. A malformed
// status tells the consumer to discard the numbers delivered for that packet.
// The parser takes one byte every cycle while the result queue (QDepth
// entries) has room; the output stage delivers one result per cycle while
// out_ch is ready. A byte that ends a message at the end of packet gives two
// results; each passes through the queue and the output register to out_ch.
module dtls_handshake_seq_extractor #(
  parameter int QDepth = dhse_pkg::DHSE_QDEPTH
) (
  input  wire         clk,
  input  wire         rst_n,
  dhse_in_if.sink     in_ch,
  dhse_out_if.source  out_ch
);
  import dhse_pkg::*;

  res_entry_t push_entry;
  res_entry_t head;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;

  dhse_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  dhse_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .full_o       (q_full),
    .empty_o      (q_empty)
  );

  dhse_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head_i  (head),
    .empty_i (q_empty),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

// ===== rtl/dhse_front.sv =====
`default_nettype none
module dhse_front (
  input  wire                  clk,
  input  wire                  rst_n,
  dhse_in_if.sink              in_ch,
  input  wire                  q_full_i,
  output logic                 push_o,
  output dhse_pkg::res_entry_t push_entry_o
);
  import dhse_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [15:0] rec_left_r, rec_left_nxt;
  logic [23:0] frag_left_r, frag_left_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic        parsed_r, parsed_nxt;
  logic        err_r, err_nxt;

  logic        accept;
  logic [7:0]  b;
  logic [3:0]  idx_inc;
  logic [15:0] rec_dec;
  logic [23:0] frag_dec;
  logic        seq_hit;
  logic [15:0] seq_out;
  logic        status_hit;
  logic        status_bad;

  assign in_ch.ready = !q_full_i;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign idx_inc     = idx_r + 4'd1;
  assign rec_dec     = rec_left_r - 16'd1;
  assign frag_dec    = frag_left_r - 24'd1;

  // Walk record and message headers for one byte
  always_comb begin
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    rec_left_nxt  = rec_left_r;
    frag_left_nxt = frag_left_r;
    seq_nxt       = seq_r;
    parsed_nxt    = parsed_r;
    err_nxt       = err_r;
    seq_hit       = 1'b0;
    seq_out       = seq_r;
    status_hit    = 1'b0;
    status_bad    = 1'b0;

    if (!err_r) begin
      unique case (phase_r)
        PH_REC_HDR: begin
          if (idx_r == REC_TYPE_POS) begin
            parsed_nxt = (b == HANDSHAKE_TYPE);
          end else if ((idx_r == REC_EPOCH_HI || idx_r == REC_EPOCH_LO) && b != 8'd0) begin
            parsed_nxt = 1'b0;
          end else if (idx_r == REC_LEN_HI) begin
            rec_left_nxt = {b, 8'd0};
          end else if (idx_r == REC_LEN_LO) begin
            rec_left_nxt = rec_left_r | {8'd0, b};
          end
          if (idx_inc >= REC_HDR_LEN) begin
            idx_nxt = 4'd0;
            if (rec_left_nxt == 16'd0) begin
              phase_nxt = PH_REC_HDR;
            end else begin
              phase_nxt = parsed_nxt ? PH_MSG_HDR : PH_SKIP;
            end
          end else begin
            idx_nxt = idx_inc;
          end
        end
        PH_SKIP: begin
          rec_left_nxt = rec_dec;
          if (rec_dec == 16'd0) begin
            phase_nxt = PH_REC_HDR;
          end
        end
        PH_MSG_HDR: begin
          rec_left_nxt = rec_dec;
          if (idx_r == MSG_SEQ_HI) begin
            seq_nxt = {b, 8'd0};
          end else if (idx_r == MSG_SEQ_LO) begin
            seq_nxt = seq_r | {8'd0, b};
          end else if (idx_r == MSG_FRAG_B2) begin
            frag_left_nxt = {b, 16'd0};
          end else if (idx_r == MSG_FRAG_B1) begin
            frag_left_nxt = frag_left_r | {8'd0, b, 8'd0};
          end else if (idx_r == MSG_FRAG_B0) begin
            frag_left_nxt = frag_left_r | {16'd0, b};
          end
          if (idx_inc >= MSG_HDR_LEN) begin
            idx_nxt = 4'd0;
            if (frag_left_nxt > {8'd0, rec_dec}) begin
              err_nxt = 1'b1;
            end else if (frag_left_nxt == 24'd0) begin
              seq_hit   = 1'b1;
              seq_out   = seq_nxt;
              phase_nxt = (rec_dec == 16'd0) ? PH_REC_HDR : PH_MSG_HDR;
            end else begin
              phase_nxt = PH_FRAGMENT;
            end
          end else begin
            idx_nxt = idx_inc;
            if (rec_dec == 16'd0) begin
              err_nxt = 1'b1;
            end
          end
        end
        PH_FRAGMENT: begin
          rec_left_nxt  = rec_dec;
          frag_left_nxt = frag_dec;
          if (frag_dec == 24'd0) begin
            seq_hit   = 1'b1;
            seq_out   = seq_r;
            phase_nxt = (rec_dec == 16'd0) ? PH_REC_HDR : PH_MSG_HDR;
          end
        end
        default: begin
          err_nxt = 1'b1;
        end
      endcase
    end

    // Report packet status and return to the start state
    if (in_ch.end_of_packet) begin
      status_hit    = 1'b1;
      status_bad    = !(!err_nxt && phase_nxt == PH_REC_HDR && idx_nxt == 4'd0);
      phase_nxt     = PH_REC_HDR;
      idx_nxt       = 4'd0;
      rec_left_nxt  = 16'd0;
      frag_left_nxt = 24'd0;
      seq_nxt       = 16'd0;
      parsed_nxt    = 1'b0;
      err_nxt       = 1'b0;
    end
  end

  // Queue the results of this byte
  assign push_o                    = accept && (seq_hit || status_hit);
  assign push_entry_o.seq_valid    = seq_hit;
  assign push_entry_o.seq          = seq_out;
  assign push_entry_o.status_valid = status_hit;
  assign push_entry_o.status_bad   = status_bad;

  // Advance parser state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_REC_HDR;
      idx_r       <= 4'd0;
      rec_left_r  <= 16'd0;
      frag_left_r <= 24'd0;
      seq_r       <= 16'd0;
      parsed_r    <= 1'b0;
      err_r       <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      rec_left_r  <= rec_left_nxt;
      frag_left_r <= frag_left_nxt;
      seq_r       <= seq_nxt;
      parsed_r    <= parsed_nxt;
      err_r       <= err_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dhse_fifo.sv =====
`default_nettype none
module dhse_fifo #(
  parameter int Depth = dhse_pkg::DHSE_QDEPTH
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push_i,
  input  dhse_pkg::res_entry_t push_entry_i,
  input  wire                  pop_i,
  output dhse_pkg::res_entry_t head_o,
  output logic                 full_o,
  output logic                 empty_o
);
  import dhse_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  res_entry_t      mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full_o  = (cnt_r == FullCnt);
  assign empty_o = (cnt_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dhse_back.sv =====
`default_nettype none
module dhse_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  dhse_pkg::res_entry_t head_i,
  input  wire                  empty_i,
  output logic                 pop_o,
  dhse_out_if.source           out_ch
);
  import dhse_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic        last_r, last_nxt;
  logic        beat_r, beat_nxt;
  logic        load;

  assign load = !out_valid_r || out_ch.ready;

  // Split each queued entry into one or two output beats
  always_comb begin
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    seq_nxt       = seq_r;
    last_nxt      = last_r;
    beat_nxt      = beat_r;
    pop_o         = 1'b0;
    if (load) begin
      if (empty_i) begin
        out_valid_nxt = 1'b0;
      end else if (head_i.seq_valid && !beat_r) begin
        out_valid_nxt = 1'b1;
        kind_nxt      = KIND_SEQ;
        seq_nxt       = head_i.seq;
        last_nxt      = !head_i.status_valid;
        if (head_i.status_valid) begin
          beat_nxt = 1'b1;
        end else begin
          pop_o = 1'b1;
        end
      end else begin
        out_valid_nxt = 1'b1;
        kind_nxt      = head_i.status_bad ? KIND_BAD : KIND_OK;
        seq_nxt       = 16'd0;
        last_nxt      = 1'b1;
        beat_nxt      = 1'b0;
        pop_o         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      beat_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      beat_r      <= beat_nxt;
    end
  end

  // Hold payload until transfer
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    seq_r  <= seq_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = kind_r;
  assign out_ch.hs_seq      = seq_r;
  assign out_ch.last_result = last_r;

endmodule
`default_nettype wire

// ===== rtl/dhse_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module dhse_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire [1:0]  out_kind,
  input wire [15:0] out_seq,
  input wire        out_last
);
  import dhse_pkg::*;

  logic        stall;
  logic        status_beat;
  logic [18:0] payload;

  assign stall       = out_valid && !out_ready;
  assign status_beat = out_valid && out_kind != KIND_SEQ;
  assign payload     = {out_kind, out_seq, out_last};

  // Stalled result stays offered
  `DHSE_ASSERT_NEXT(a_valid_hold, clk, rst_n, stall, out_valid, "result dropped while stalled")

  // Stalled result keeps its payload
  `DHSE_ASSERT_NEXT(a_payload_hold, clk, rst_n, stall, $stable(payload), "payload changed in stall")

  // Status results carry no sequence number
  `DHSE_ASSERT_NOW(a_status_seq_zero, clk, rst_n, status_beat, out_seq == 16'd0, "status with seq")

  // Status always closes the results of its byte
  `DHSE_ASSERT_NOW(a_status_last, clk, rst_n, status_beat, out_last, "status not marked last")

endmodule

bind dtls_handshake_seq_extractor dhse_checker u_dhse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.result_kind),
  .out_seq   (out_ch.hs_seq),
  .out_last  (out_ch.last_result)
);
`default_nettype wire
